// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Widths, register indexes and sequencer states of the trapezoid pulse source.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int TIME_BITS     = 24;
    localparam int SAMPLE_BITS   = 16;
    localparam int SUM_BITS      = TIME_BITS + 2;
    localparam int PROD_BITS     = SAMPLE_BITS + TIME_BITS;
    localparam int DQ_BITS       = (TIME_BITS > SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS;
    localparam int CNT_BITS      = $clog2(DQ_BITS + 1);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = DQ_BITS;
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PEAK   = 3'd0,
        REG_DELAY  = 3'd1,
        REG_RISE   = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_FALL   = 3'd4,
        REG_PERIOD = 3'd5,
        REG_STOP   = 3'd6
    } tps_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } tps_state_t;

endpackage

// ===== rtl/trapezoid_pulse_source_unit.sv =====
// ----------------------------------------------------------------------------
// trapezoid_pulse_source_unit
// Periodic trapezoid pulse generator, one sample word per input word.
// ----------------------------------------------------------------------------
// Each accepted input word yields one sample of the trapezoid at the current
// tick, after which the tick advances (and saturates). All timing comes from
// one shared restoring divider that resolves one bit per cycle: it finds the
// phase within the period in a TIME_BITS-bit divide, and a ramp sample takes a
// multiply step plus a SAMPLE_BITS-bit divide; a sample before the delay or
// past the stop tick skips both, and a zero period skips the phase divide.
// The input is not ready while a sample is in work. Registers must be written
// through the cfg port only while the unit is idle; the block does not
// enforce this. cfg_ready is always 1.
// ----------------------------------------------------------------------------
module trapezoid_pulse_source_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tps_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,   // [0] restart
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tps_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,   // [15:0] sample
    output logic                               m_axis_tuser    // [0] done_res
);

    import tps_pkg::*;

    tps_state_t                     state_reg, state_next;
    logic [TIME_BITS-1:0]           time_reg, time_next;
    logic                           out_valid_reg, out_valid_next;

    logic signed [SAMPLE_BITS-1:0]  peak_reg;
    logic [TIME_BITS-1:0]           delay_reg;
    logic [TIME_BITS-1:0]           rise_reg;
    logic [TIME_BITS-1:0]           width_reg;
    logic [TIME_BITS-1:0]           fall_reg;
    logic [TIME_BITS-1:0]           period_reg;
    logic [TIME_BITS-1:0]           stop_reg;

    logic [TIME_BITS-1:0]           t_reg, t_next;
    logic [TIME_BITS-1:0]           rem_reg, rem_next;
    logic [DQ_BITS-1:0]             dq_reg, dq_next;
    logic [TIME_BITS-1:0]           den_reg, den_next;
    logic [TIME_BITS-1:0]           num_reg, num_next;
    logic [CNT_BITS-1:0]            cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0]         res_reg, res_next;
    logic                           done_reg, done_next;
    logic [SAMPLE_BITS-1:0]         out_data_reg, out_data_next;
    logic                           out_done_reg, out_done_next;

    logic                           in_fire;
    logic [TIME_BITS-1:0]           t_cur;
    logic [TIME_BITS-1:0]           u_cur;
    logic [TIME_BITS:0]             trial;
    logic                           trial_ok;
    logic [TIME_BITS-1:0]           phase;
    logic [TIME_BITS-1:0]           start_t;
    logic [SUM_BITS-1:0]            sum_r;
    logic [SUM_BITS-1:0]            sum_rw;
    logic [SUM_BITS-1:0]            sum_rwf;
    logic [SUM_BITS-1:0]            phase_x;
    logic [SUM_BITS-1:0]            start_x;
    logic [SUM_BITS-1:0]            stop_x;
    logic                           neg;
    logic [SAMPLE_BITS-1:0]         mag;
    logic [PROD_BITS-1:0]           prod;
    logic [SAMPLE_BITS-1:0]         quo;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(out_data_reg);
    assign m_axis_tuser  = out_done_reg;

    assign t_cur    = s_axis_tdata[0] ? '0 : time_reg;
    assign u_cur    = t_cur - delay_reg;
    assign trial    = {rem_reg, dq_reg[DQ_BITS-1]} - {1'b0, den_reg};
    assign trial_ok = ({rem_reg, dq_reg[DQ_BITS-1]} >= {1'b0, den_reg});

    assign phase   = rem_reg;
    assign start_t = t_reg - phase;
    assign sum_r   = SUM_BITS'(rise_reg);
    assign sum_rw  = sum_r + SUM_BITS'(width_reg);
    assign sum_rwf = sum_rw + SUM_BITS'(fall_reg);
    assign phase_x = SUM_BITS'(phase);
    assign start_x = SUM_BITS'(start_t);
    assign stop_x  = SUM_BITS'(stop_reg);

    assign neg  = peak_reg[SAMPLE_BITS-1];
    assign mag  = neg ? SAMPLE_BITS'(-peak_reg) : SAMPLE_BITS'(peak_reg);
    assign prod = PROD_BITS'(mag) * PROD_BITS'(num_reg);
    assign quo  = dq_reg[SAMPLE_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        out_valid_next = out_valid_reg;
        t_next         = t_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        done_next      = done_reg;
        out_data_next  = out_data_reg;
        out_done_next  = out_done_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    t_next    = t_cur;
                    time_next = (t_cur == '1) ? t_cur : t_cur + 1'b1;
                    done_next = (t_cur >= stop_reg);
                    if ((t_cur >= stop_reg) || (t_cur < delay_reg))
                    begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end
                    else if (period_reg == '0)
                    begin
                        rem_next   = u_cur;
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        rem_next   = '0;
                        dq_next    = DQ_BITS'(u_cur) << (DQ_BITS - TIME_BITS);
                        den_next   = period_reg;
                        cnt_next   = CNT_BITS'(TIME_BITS);
                        state_next = ST_MOD;
                    end
                end
            end

            ST_MOD, ST_DIV:
            begin
                rem_next = trial_ok ? trial[TIME_BITS-1:0]
                                    : {rem_reg[TIME_BITS-2:0], dq_reg[DQ_BITS-1]};
                dq_next  = {dq_reg[DQ_BITS-2:0], trial_ok};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    if (state_reg == ST_MOD)
                    begin
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        res_next   = neg ? -{quo[SAMPLE_BITS-2:0], trial_ok}
                                         : {quo[SAMPLE_BITS-2:0], trial_ok};
                        state_next = ST_OUT;
                    end
                end
            end

            ST_EVAL:
            begin
                state_next = ST_OUT;
                res_next   = '0;
                if (phase_x < sum_r)
                begin
                    if ((start_x + sum_r) < stop_x)
                    begin
                        num_next   = phase;
                        den_next   = rise_reg;
                        state_next = ST_MUL;
                    end
                end
                else if (phase_x < sum_rw)
                begin
                    if ((start_x + sum_rw) < stop_x)
                    begin
                        res_next = peak_reg;
                    end
                end
                else if (phase_x < sum_rwf)
                begin
                    if ((start_x + sum_rwf) < stop_x)
                    begin
                        num_next   = TIME_BITS'(sum_rwf - phase_x);
                        den_next   = fall_reg;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                rem_next   = prod[PROD_BITS-1:SAMPLE_BITS];
                dq_next    = DQ_BITS'(prod[SAMPLE_BITS-1:0]) << (DQ_BITS - SAMPLE_BITS);
                cnt_next   = CNT_BITS'(SAMPLE_BITS);
                state_next = ST_DIV;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_done_next  = done_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
            delay_reg     <= '0;
            rise_reg      <= '0;
            width_reg     <= '0;
            fall_reg      <= '0;
            period_reg    <= TIME_BITS'(1);
            stop_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PEAK:   peak_reg   <= cfg_data[SAMPLE_BITS-1:0];
                    REG_DELAY:  delay_reg  <= cfg_data[TIME_BITS-1:0];
                    REG_RISE:   rise_reg   <= cfg_data[TIME_BITS-1:0];
                    REG_WIDTH:  width_reg  <= cfg_data[TIME_BITS-1:0];
                    REG_FALL:   fall_reg   <= cfg_data[TIME_BITS-1:0];
                    REG_PERIOD: period_reg <= cfg_data[TIME_BITS-1:0];
                    REG_STOP:   stop_reg   <= cfg_data[TIME_BITS-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        done_reg     <= done_next;
        out_data_reg <= out_data_next;
        out_done_reg <= out_done_next;
    end

endmodule

// ===== rtl/tps_checker.sv =====
// ----------------------------------------------------------------------------
// tps_checker
// Port-level checks for the trapezoid pulse source, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tps_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [tps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [tps_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [tps_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                               m_axis_tuser
);

    import tps_pkg::*;

    logic in_fire;
    logic out_stall;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output word changed")
    `ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "input ready while a word is in work")
    `ASSERT_SAME(a_done_is_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "nonzero sample after stop tick")
    `ASSERT_NEXT(a_cfg_always_ready, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind trapezoid_pulse_source_unit tps_checker u_tps_checker (.*);
